// ===== design/clf_pkg.sv =====
// ----------------------------------------------------------------------------
// clf_pkg: shared types and constants of the command line framer checker
// Request payload types, result kinds, error flags, character codes and the
// queue entry between the front and back parts.
// ----------------------------------------------------------------------------
package clf_pkg;

	localparam int SLOTS    = 4;
	localparam int LINE_LEN = 64;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int IDX_W    = $clog2(LINE_LEN);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int MEM_W    = SLOT_W + IDX_W;
	localparam int JQ_DEPTH = 2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [3:0] ERR_NUM_MISMATCH = 4'b0001;
	localparam logic [3:0] ERR_NO_NUM       = 4'b0010;
	localparam logic [3:0] ERR_SUM_MISMATCH = 4'b0100;
	localparam logic [3:0] ERR_NO_SUM       = 4'b1000;

	localparam logic [1:0] CFG_LINE_CHECK = 2'd0;
	localparam logic [1:0] CFG_SUM_CHECK  = 2'd1;
	localparam logic [1:0] CFG_COMMENT    = 2'd2;

	// number scanner phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LEAD  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	typedef enum logic [2:0] {
		KIND_ACCEPT  = 3'd0,
		KIND_REJECT  = 3'd1,
		KIND_CHAR    = 3'd2,
		KIND_REFUSED = 3'd3,
		KIND_EMPTY   = 3'd4
	} kind_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  error_flags;
		logic [31:0] resend_number;
		logic [5:0]  slot;
		logic [7:0]  char_out;
		logic        last;
		logic [6:0]  stored_count;
	} out_item_t;

	// queue entry: one event for the back part
	typedef struct packed {
		logic              pop;       // emit a stored line
		logic [SLOT_W-1:0] rslot;
		logic [IDX_W-1:0]  len;
		out_item_t         res;       // single result when not a pop
	} job_t;

endpackage

// ===== design/clf_front.sv =====
// ----------------------------------------------------------------------------
// clf_front: byte classifier and line checker
// Stores bytes, scans N and star numbers, decides lines, keeps ring counts and
// pushes one job per request that yields results.
// ----------------------------------------------------------------------------
module clf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  clf_pkg::in_item_t         in_data,
	output logic                      job_valid,
	input  logic                      job_full,
	output clf_pkg::job_t             job,
	output logic                      mem_we,
	output logic [clf_pkg::MEM_W-1:0] mem_addr,
	output logic [7:0]                mem_data,
	input  logic                      pop_done
);
	import clf_pkg::*;

	logic line_en_q, sum_en_q, cmt_en_q;
	logic [SLOT_W-1:0] wslot_q, rslot_q;
	logic [CNT_W-1:0]  held_q;
	logic [IDX_W-1:0]  cidx_q;
	logic [7:0]        xsum_q, first_q;
	logic [1:0]        np_q, sp_q;
	logic              nneg_q, sneg_q;
	logic [31:0]       nmag_q, last_num_q;
	logic [15:0]       smag_q;
	logic [IDX_W-1:0]  len_q [SLOTS];
	logic              pop_busy_q;    // popped line still being read out

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_en_q <= 1'b1;
			sum_en_q  <= 1'b1;
			cmt_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_CHECK: line_en_q <= cfg_data;
				CFG_SUM_CHECK:  sum_en_q  <= cfg_data;
				CFG_COMMENT:    cmt_en_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
	endfunction

	logic [7:0] c;
	logic       acc, is_pop, full, term, digit;
	logic [3:0] dval;
	logic [1:0] np_n, sp_n;
	logic       nneg_n, sneg_n;
	logic [31:0] nmag_n, nval, want;
	logic [15:0] smag_n;
	logic [35:0] nmul;
	logic [19:0] smul;
	logic [3:0]  flags;
	logic        commit, drop_line;

	assign c      = in_data.rx_byte;
	assign is_pop = in_data.mode;
	assign full   = held_q == CNT_W'(SLOTS);
	// one job per request at most; stall while the queue is full or while a
	// popped slot is still read, since new bytes may land in that slot
	assign in_stall = job_full || pop_busy_q;
	assign acc    = in_valid && !in_stall;
	assign term   = c == CH_CR || c == CH_LF || c == CH_COLON ||
	                cidx_q == IDX_W'(LINE_LEN - 1);
	assign digit  = c >= CH_0 && c <= CH_9;
	assign dval   = 4'(c - CH_0);
	assign want   = last_num_q + 32'd1;

	// incremental number scanners
	always_comb begin
		np_n = np_q; nneg_n = nneg_q; nmag_n = nmag_q;
		nmul = {4'd0, nmag_q} * 36'd10 + {32'd0, dval};
		if (np_q == PH_IDLE) begin
			if (c == CH_N) np_n = PH_LEAD;
		end else if (np_q == PH_LEAD && is_ws(c)) begin
			np_n = PH_LEAD;
		end else if (np_q == PH_LEAD && c == CH_PLUS) begin
			np_n = PH_DIGIT;
		end else if (np_q == PH_LEAD && c == CH_MINUS) begin
			np_n = PH_DIGIT; nneg_n = 1'b1;
		end else if (np_q != PH_DONE && digit) begin
			np_n = PH_DIGIT;
			nmag_n = nmul > 36'h080000000 ? 32'h80000000 : nmul[31:0];
		end else begin
			np_n = PH_DONE;
		end
		sp_n = sp_q; sneg_n = sneg_q; smag_n = smag_q;
		smul = {4'd0, smag_q} * 20'd10 + {16'd0, dval};
		if (sp_q == PH_IDLE) begin
			if (c == CH_STAR) sp_n = PH_LEAD;
		end else if (sp_q == PH_LEAD && is_ws(c)) begin
			sp_n = PH_LEAD;
		end else if (sp_q == PH_LEAD && c == CH_PLUS) begin
			sp_n = PH_DIGIT;
		end else if (sp_q == PH_LEAD && c == CH_MINUS) begin
			sp_n = PH_DIGIT; sneg_n = 1'b1;
		end else if (sp_q != PH_DONE && digit) begin
			sp_n = PH_DIGIT;
			smag_n = smul > 20'h0FFFF ? 16'hFFFF : smul[15:0];
		end else begin
			sp_n = PH_DONE;
		end
	end

	// line checks
	always_comb begin
		flags = 4'd0;
		if (nneg_q) nval = 32'd0 - nmag_q;
		else nval = nmag_q > 32'h7FFFFFFF ? 32'h7FFFFFFF : nmag_q;
		if (line_en_q) begin
			if (np_q == PH_IDLE) flags = flags | ERR_NO_NUM;
			else if (nval != want) flags = flags | ERR_NUM_MISMATCH;
		end
		if (sum_en_q) begin
			if (sp_q == PH_IDLE) flags = flags | ERR_NO_SUM;
			else if (smag_q != {8'd0, xsum_q} || (sneg_q && smag_q != 16'd0))
				flags = flags | ERR_SUM_MISMATCH;
		end
	end

	logic byte_req, end_req, store_req;
	assign byte_req  = acc && !is_pop && !full;
	assign end_req   = byte_req && term && cidx_q != '0;
	assign drop_line = cmt_en_q && first_q == CH_SEMI;
	assign commit    = end_req && !drop_line && flags == 4'd0;
	assign store_req = byte_req && !term;

	assign mem_we   = store_req;
	assign mem_addr = {wslot_q, cidx_q};
	assign mem_data = c;

	// job building
	always_comb begin
		job = '0;
		job.rslot = rslot_q;
		job.len   = len_q[rslot_q];
		job.res.stored_count = 7'(held_q);
		job_valid = 1'b0;
		if (acc && is_pop) begin
			job_valid = 1'b1;
			if (held_q == '0) begin
				job.res.kind = KIND_EMPTY;
			end else begin
				job.pop = 1'b1;
				job.res.stored_count = 7'(held_q - CNT_W'(1));
			end
		end else if (acc && full) begin
			job_valid = 1'b1;
			job.res.kind = KIND_REFUSED;
		end else if (end_req && !drop_line) begin
			job_valid = 1'b1;
			job.res.slot = 6'(wslot_q);
			if (flags != 4'd0) begin
				job.res.kind = KIND_REJECT;
				job.res.error_flags = flags;
				job.res.resend_number = want;
			end else begin
				job.res.kind = KIND_ACCEPT;
				job.res.stored_count = 7'(held_q + CNT_W'(1));
			end
		end
	end

	logic do_pop;
	assign do_pop = acc && is_pop && held_q != '0;

	// ring and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0; rslot_q <= '0; held_q <= '0; last_num_q <= '0;
			cidx_q <= '0; xsum_q <= '0; np_q <= PH_IDLE; sp_q <= PH_IDLE;
			nneg_q <= 1'b0; sneg_q <= 1'b0; nmag_q <= '0; smag_q <= '0;
			pop_busy_q <= 1'b0;
		end else begin
			if (do_pop) pop_busy_q <= 1'b1;
			else if (pop_done) pop_busy_q <= 1'b0;
			if (do_pop) rslot_q <= SLOT_W'((32'(rslot_q) + 1) % SLOTS);
			held_q <= CNT_W'(32'(held_q) + (commit ? 1 : 0) - (do_pop ? 1 : 0));
			if (commit) begin
				wslot_q <= SLOT_W'((32'(wslot_q) + 1) % SLOTS);
				if (line_en_q) last_num_q <= nval;
			end
			if (end_req) begin
				cidx_q <= '0; xsum_q <= '0; np_q <= PH_IDLE; sp_q <= PH_IDLE;
				nneg_q <= 1'b0; sneg_q <= 1'b0; nmag_q <= '0; smag_q <= '0;
			end else if (store_req) begin
				cidx_q <= cidx_q + IDX_W'(1);
				if (sp_q == PH_IDLE && c != CH_STAR) xsum_q <= xsum_q ^ c;
				np_q <= np_n; nneg_q <= nneg_n; nmag_q <= nmag_n;
				sp_q <= sp_n; sneg_q <= sneg_n; smag_q <= smag_n;
			end
		end
	end

	// first character and slot lengths
	always_ff @(posedge clk) begin
		if (store_req && cidx_q == '0) first_q <= c;
		if (commit) len_q[wslot_q] <= cidx_q;
	end
endmodule

// ===== design/clf_back.sv =====
// ----------------------------------------------------------------------------
// clf_back: result sequencer
// Holds a short job queue, reads popped lines out of the line memory one
// character a cycle while out_stall is low and drives the result register.
// ----------------------------------------------------------------------------
module clf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_full,
	input  clf_pkg::job_t             job,
	input  logic                      mem_we,
	input  logic [clf_pkg::MEM_W-1:0] mem_addr,
	input  logic [7:0]                mem_data,
	output logic                      pop_done,
	output logic                      out_valid,
	input  logic                      out_stall,
	output clf_pkg::out_item_t        out_data
);
	import clf_pkg::*;

	job_t   q_q [JQ_DEPTH];
	logic   wp_q, rp_q;
	logic [1:0] qn_q;
	logic   q_push, q_pop;
	job_t   head;

	logic [7:0] mem [SLOTS * LINE_LEN];

	logic       busy_q;        // emitting a popped line
	logic [IDX_W-1:0] k_q, len_q;
	logic [SLOT_W-1:0] rs_q;
	logic [6:0] cnt_q;
	logic       rd_v_s1, rd_last_s1;
	logic [7:0] rd_s1;
	logic       ov_q;
	out_item_t  od_q;

	assign head     = q_q[rp_q];
	assign job_full = qn_q == 2'(JQ_DEPTH);
	assign q_push   = job_valid && !job_full;

	logic out_free, issue, take_job, empty_len;

	// line memory; read data held until the next issued read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_data;
		if (issue) rd_s1 <= mem[{rs_q, k_q}];
	end

	assign out_free  = !ov_q || !out_stall;
	// issue a memory read when the stage after it can drain
	assign issue     = busy_q && (!rd_v_s1 || out_free);
	assign empty_len = head.len == '0;
	assign take_job  = !busy_q && !rd_v_s1 && qn_q != 2'd0 && out_free;
	assign q_pop     = take_job;
	assign pop_done  = issue && (k_q + IDX_W'(1) == len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; qn_q <= '0;
			busy_q <= 1'b0; rd_v_s1 <= 1'b0; ov_q <= 1'b0;
		end else begin
			if (q_push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			qn_q <= 2'(qn_q + (q_push ? 2'd1 : 2'd0) - (q_pop ? 2'd1 : 2'd0));
			if (take_job && head.pop && !empty_len) busy_q <= 1'b1;
			else if (issue && k_q + IDX_W'(1) == len_q) busy_q <= 1'b0;
			if (issue) rd_v_s1 <= 1'b1;
			else if (out_free) rd_v_s1 <= 1'b0;
			if (take_job || (rd_v_s1 && out_free)) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) q_q[wp_q] <= job;
		if (take_job) begin
			k_q <= '0; len_q <= head.len; rs_q <= head.rslot;
			cnt_q <= head.res.stored_count;
		end else if (issue) begin
			k_q <= k_q + IDX_W'(1);
		end
		if (issue) rd_last_s1 <= k_q + IDX_W'(1) == len_q;
		// result register
		if (take_job) begin
			if (head.pop && empty_len) begin
				od_q <= '0;
				od_q.kind <= KIND_CHAR; od_q.slot <= 6'(head.rslot);
				od_q.last <= 1'b1; od_q.stored_count <= head.res.stored_count;
			end else if (!head.pop) begin
				od_q <= head.res;
			end
		end else if (rd_v_s1 && out_free) begin
			od_q <= '0;
			od_q.kind <= KIND_CHAR; od_q.slot <= 6'(rs_q);
			od_q.char_out <= rd_s1; od_q.last <= rd_last_s1;
			od_q.stored_count <= cnt_q;
		end
	end

	// a nonempty pop job loads no result itself
	logic ld_none;
	assign ld_none = take_job && head.pop && !empty_len;
	logic ov_real_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_real_q <= 1'b0;
		else if ((take_job && !ld_none) || (rd_v_s1 && out_free)) ov_real_q <= 1'b1;
		else if (!out_stall) ov_real_q <= 1'b0;
	end

	assign out_valid = ov_real_q;
	assign out_data  = od_q;
endmodule

// ===== design/command_line_framer_checker_top.sv =====
// ----------------------------------------------------------------------------
// command_line_framer_checker_top: command line framer and checker
// Frames received bytes into lines, checks line number and checksum, keeps
// good lines in a ring and replays them on pop requests.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall   | in_data  (mode, rx_byte)
// out     | output    | out_valid/out_stall | out_data (kind .. stored_count)
// cfg     | input     | cfg_we              | cfg_index, cfg_data
// A single result passes the two-entry job queue into the result register;
// the first character of a popped line also passes the memory read stage.
// A popped line streams one character per cycle from memory while unstalled.
// Reset sets pointers, counts, flags and config; line memory is not reset.
// in_stall rises while the job queue is full and while a popped line is read
// out; out_stall holds results.
module command_line_framer_checker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  clf_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output clf_pkg::out_item_t  out_data
);
	import clf_pkg::*;

	logic job_valid, job_full, mem_we, pop_done;
	job_t job;
	logic [MEM_W-1:0] mem_addr;
	logic [7:0] mem_data;

	clf_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .in_data,
		.job_valid, .job_full, .job,
		.mem_we, .mem_addr, .mem_data, .pop_done
	);

	clf_back u_back (
		.clk, .arst_n, .job_valid, .job_full, .job,
		.mem_we, .mem_addr, .mem_data, .pop_done,
		.out_valid, .out_stall, .out_data
	);
endmodule

// ===== design/clf_checker.sv =====
// ----------------------------------------------------------------------------
// clf_checker: port checks of the framer checker
// Watches the top level ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module clf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input clf_pkg::out_item_t out_data
);
	import clf_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// stalled request stays offered
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled request withdrawn");

	// kind stays in its code range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind <= KIND_EMPTY)
		else $error("bad kind");

	// error flags only on rejects
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_REJECT |-> out_data.error_flags == 4'd0)
		else $error("flags outside reject");

	// stored count never exceeds ring size
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.stored_count <= 7'(SLOTS))
		else $error("count over ring size");
endmodule

bind command_line_framer_checker_top clf_checker u_clf_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
